### design/kbpd_pkg.sv
// Shared types and constants for the keyboard report press detector.
package kbpd_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_KEYS = 6;
    localparam int LATER_KEYS  = REPORT_KEYS - 1;
    localparam int CODE_W      = 8;
    localparam int STEP_W      = $clog2(REPORT_KEYS);

    typedef logic [CODE_W-1:0] code_t;

    typedef struct packed {
        logic [7:0] modifier;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } report_t;

    typedef struct packed {
        logic [7:0] pressed_code;
        logic [7:0] pressed_modifier;
        logic       last_event;
    } press_t;

    typedef struct packed {
        logic advance;
        logic first;
        logic finish;
    } cell_ctl_t;

    typedef struct packed {
        logic                  hit;
        logic                  empty_after;
        logic [LATER_KEYS-1:0] later_hit;
    } cell_stat_t;

endpackage

### design/kbpd_cell.sv
// One held-key cell: stores a code, claims an empty slot, tracks presence.
module kbpd_cell (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  kbpd_pkg::cell_ctl_t                      ctl,
    input  kbpd_pkg::code_t                          code,
    input  logic [kbpd_pkg::LATER_KEYS-1:0][kbpd_pkg::CODE_W-1:0] later,
    input  logic                                     claim_in,
    output logic                                     claim_out,
    output kbpd_pkg::cell_stat_t                     stat
);
    import kbpd_pkg::*;

    code_t key_reg;
    code_t key_next;
    code_t key_after;
    logic  present_reg;
    logic  present_next;
    logic  present_now;
    logic  empty;
    logic  store;

    always_comb
    begin
        empty       = (key_reg == '0);
        store       = claim_in && empty;
        key_after   = store ? code : key_reg;
        present_now = (present_reg && !ctl.first) || (key_reg == code) || store;
        claim_out   = claim_in && !empty;

        stat.hit         = (key_reg == code);
        stat.empty_after = (key_after == '0);
        for (int j = 0; j < LATER_KEYS; j++)
        begin
            stat.later_hit[j] = (key_after == later[j]);
        end

        key_next     = key_reg;
        present_next = present_reg;
        if (ctl.advance)
        begin
            present_next = present_now;
            if (ctl.finish && !present_now)
            begin
                key_next = '0;
            end
            else
            begin
                key_next = key_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            present_reg <= 1'b0;
        end
        else
        begin
            key_reg     <= key_next;
            present_reg <= present_next;
        end
    end

endmodule

### design/kbpd_out_fifo.sv
// Two-entry output queue for press beats.
module kbpd_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  kbpd_pkg::press_t push_data,
    output logic            space,
    output logic            press_valid,
    input  logic            press_stall,
    output kbpd_pkg::press_t press
);
    import kbpd_pkg::*;

    press_t     data_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        space       = (count_reg != 2'd2);
        press_valid = (count_reg != 2'd0);
        press       = data_reg[rd_ptr_reg];
        do_push     = push && space;
        do_pop      = press_valid && !press_stall;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/keyboard_report_press_detect.sv
// Keyboard report press detector: top level with scan sequencer and held-key cells.
// Each report's key codes are scanned one per cycle, while the output queue has space,
// through a row of held-key cells, and the next report is taken in the cycle its
// predecessor's last code is scanned. A press beat leaves for each newly stored code,
// in report order, with last_event marking the final one of a report; a report that
// presses nothing gives no beat. Press beats pass through a two-entry queue, and the
// scan holds while that queue is full.
module keyboard_report_press_detect (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_stall,
    input  kbpd_pkg::report_t report,
    output logic              press_valid,
    input  logic              press_stall,
    output kbpd_pkg::press_t  press
);
    import kbpd_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(REPORT_KEYS - 1);

    code_t             code_reg [REPORT_KEYS];
    code_t             code_next [REPORT_KEYS];
    logic [7:0]        mod_reg;
    logic [7:0]        mod_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;

    logic                                  space;
    logic                                  advance;
    logic                                  final_step;
    logic                                  accept;
    logic                                  held_any;
    logic                                  empty_any;
    logic                                  more;
    logic                                  press_new;
    wire  [KEY_SLOTS:0]                    claim;
    logic [LATER_KEYS-1:0][CODE_W-1:0]     later;
    logic [LATER_KEYS-1:0]                 later_held;
    cell_ctl_t                             ctl;
    cell_stat_t                            stat [KEY_SLOTS];
    press_t                                push_data;

    always_comb
    begin
        for (int j = 0; j < LATER_KEYS; j++)
        begin
            later[j] = code_reg[j+1];
        end
    end

    always_comb
    begin
        held_any   = 1'b0;
        empty_any  = 1'b0;
        later_held = '0;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            held_any   = held_any | stat[k].hit;
            empty_any  = empty_any | stat[k].empty_after;
            later_held = later_held | stat[k].later_hit;
        end
    end

    assign claim[0]  = (code_reg[0] != '0) && !held_any;
    assign press_new = claim[0] && !claim[KEY_SLOTS];

    always_comb
    begin
        more = 1'b0;
        for (int j = 0; j < LATER_KEYS; j++)
        begin
            more = more | ((later[j] != '0) && !later_held[j]);
        end
        more = more && empty_any;

        push_data.pressed_code     = code_reg[0];
        push_data.pressed_modifier = mod_reg;
        push_data.last_event       = !more;
    end

    always_comb
    begin
        advance      = busy_reg && space;
        final_step   = (step_reg == LAST_STEP);
        report_stall = busy_reg && !(advance && final_step);
        accept       = report_valid && !report_stall;

        ctl.advance = advance;
        ctl.first   = (step_reg == '0);
        ctl.finish  = final_step;

        code_next = code_reg;
        mod_next  = mod_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            code_next[0] = report.key_slot_0;
            code_next[1] = report.key_slot_1;
            code_next[2] = report.key_slot_2;
            code_next[3] = report.key_slot_3;
            code_next[4] = report.key_slot_4;
            code_next[5] = report.key_slot_5;
            mod_next     = report.modifier;
            step_next    = '0;
            busy_next    = 1'b1;
        end
        else if (advance)
        begin
            for (int j = 0; j < LATER_KEYS; j++)
            begin
                code_next[j] = code_reg[j+1];
            end
            code_next[REPORT_KEYS-1] = '0;
            step_next = step_reg + 1'b1;
            if (final_step)
            begin
                busy_next = 1'b0;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < KEY_SLOTS; g++)
        begin : g_cell
            kbpd_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .code      (code_reg[0]),
                .later     (later),
                .claim_in  (claim[g]),
                .claim_out (claim[g+1]),
                .stat      (stat[g])
            );
        end
    endgenerate

    kbpd_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (advance && press_new),
        .push_data   (push_data),
        .space       (space),
        .press_valid (press_valid),
        .press_stall (press_stall),
        .press       (press)
    );

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        mod_reg  <= mod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

endmodule
